[hw/rtl/text_mode_terminal_writer_top_defines.svh]
// assertion macros used by the port checker
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define TMTW_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmtw assertion failed");

// checked on every clock edge, reset included
`define TMTW_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tmtw assertion failed during or after reset");

`endif

[hw/rtl/tmtw_pkg.sv]
package tmtw_pkg;

    localparam int FUNC_W   = 1;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int ENTRY_W  = 16;
    localparam int COLOUR_W = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [FUNC_W-1:0]   FUNC_PUT  = 1'b0;
    localparam logic [FUNC_W-1:0]   FUNC_READ = 1'b1;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
    localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h07;

    // register index, taken from paddr[2]
    localparam logic REG_TEXT_COLOUR = 1'b0;

    typedef struct packed {
        logic capture;
        logic calc_addr;
        logic put_write;
        logic next_row;
        logic scroll_setup;
        logic scroll_write;
        logic clear_write;
        logic read;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_newline;
        logic col_last;
        logic row_last;
        logic fill_last;
        logic clear_last;
    } ctrl_sts_t;

endpackage

[hw/rtl/tmtw_if.sv]
interface tmtw_in_if
    import tmtw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_column;

    modport source (output valid, func, char_code, read_row, read_column, input ready);
    modport sink   (input valid, func, char_code, read_row, read_column, output ready);
endinterface

interface tmtw_out_if
    import tmtw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] read_entry;
    logic [RROW_W-1:0]  cursor_row;
    logic [RCOL_W-1:0]  cursor_column;
    logic               scrolled;

    modport source (output valid, read_entry, cursor_row, cursor_column, scrolled,
                    input ready);
    modport sink   (input valid, read_entry, cursor_row, cursor_column, scrolled,
                    output ready);
endinterface

[hw/rtl/tmtw_ram.sv]
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tmtw_ctrl.sv]
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR        = 9'b000000001,
        ST_IDLE         = 9'b000000010,
        ST_ADDR         = 9'b000000100,
        ST_PUT          = 9'b000001000,
        ST_NEWROW       = 9'b000010000,
        ST_SCROLL_SETUP = 9'b000100000,
        ST_SCROLL       = 9'b001000000,
        ST_READ         = 9'b010000000,
        ST_DONE         = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                if (sts.is_read)
                begin
                    state_next = ST_READ;
                end
                else if (sts.is_newline)
                begin
                    state_next = ST_NEWROW;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                cmd.put_write = 1'b1;
                state_next    = sts.col_last ? ST_NEWROW : ST_DONE;
            end
            ST_NEWROW:
            begin
                cmd.next_row = 1'b1;
                state_next   = sts.row_last ? ST_SCROLL_SETUP : ST_DONE;
            end
            ST_SCROLL_SETUP:
            begin
                cmd.scroll_setup = 1'b1;
                state_next       = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                cmd.scroll_write = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/tmtw_datapath.sv]
module tmtw_datapath
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic [COLOUR_W-1:0] text_colour,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [RROW_W-1:0]   read_row,
    input  logic [RCOL_W-1:0]   read_column,
    output logic [ENTRY_W-1:0]  read_entry,
    output logic [RROW_W-1:0]   cursor_row,
    output logic [RCOL_W-1:0]   cursor_column,
    output logic                scrolled
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int SUM_W  = ROW_W + 1;

    logic [FUNC_W-1:0]  req_func_reg;
    logic [CHAR_W-1:0]  req_char_reg;
    logic [RROW_W-1:0]  req_row_reg;
    logic [RCOL_W-1:0]  req_col_reg;

    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [ROW_W-1:0]   top_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               range_ok_reg;
    logic [ADDR_W-1:0]  fill_addr_reg;
    logic [COL_W-1:0]   fill_cnt_reg;
    logic               scrolled_reg;

    logic [ENTRY_W-1:0] res_entry_reg;
    logic [RROW_W-1:0]  res_row_reg;
    logic [RCOL_W-1:0]  res_col_reg;
    logic               res_scrolled_reg;

    logic               is_read;
    logic               range_ok_next;
    logic [ROW_W-1:0]   row_sel;
    logic [COL_W-1:0]   col_sel;
    logic [SUM_W-1:0]   phys_sum;
    logic [ROW_W-1:0]   phys_row;
    logic [ADDR_W-1:0]  addr_next;
    logic [ROW_W-1:0]   top_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    assign is_read = (req_func_reg == FUNC_READ);

    assign sts.is_read    = is_read;
    assign sts.is_newline = (req_char_reg == NEWLINE_CODE);
    assign sts.col_last   = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign sts.row_last   = (cur_row_reg == ROW_W'(ROWS - 1));
    assign sts.fill_last  = (fill_cnt_reg == COL_W'(COLUMNS - 1));
    assign sts.clear_last = (fill_addr_reg == ADDR_W'(TOTAL - 1));

    // logical row to physical row through the rotating top pointer
    always_comb
    begin
        range_ok_next = (8'(req_row_reg) < 8'(ROWS)) && (9'(req_col_reg) < 9'(COLUMNS));
        row_sel       = is_read ? ROW_W'(req_row_reg) : cur_row_reg;
        col_sel       = is_read ? COL_W'(req_col_reg) : cur_col_reg;
        phys_sum      = {1'b0, row_sel} + {1'b0, top_reg};
        if (phys_sum >= SUM_W'(ROWS))
        begin
            phys_sum = phys_sum - SUM_W'(ROWS);
        end
        phys_row  = phys_sum[ROW_W-1:0];
        addr_next = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
        if (is_read && !range_ok_next)
        begin
            addr_next = '0;
        end
        top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
    end

    always_comb
    begin
        wr_en   = cmd.clear_write || cmd.put_write || cmd.scroll_write;
        wr_addr = cmd.put_write ? addr_reg : fill_addr_reg;
        if (cmd.clear_write)
        begin
            wr_data = {RESET_COLOUR, SPACE_CODE};
        end
        else if (cmd.put_write)
        begin
            wr_data = {text_colour, req_char_reg};
        end
        else
        begin
            wr_data = {text_colour, SPACE_CODE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_func_reg <= func;
            req_char_reg <= char_code;
            req_row_reg  <= read_row;
            req_col_reg  <= read_column;
        end
        if (cmd.calc_addr)
        begin
            addr_reg     <= addr_next;
            range_ok_reg <= range_ok_next;
        end
        if (cmd.scroll_setup)
        begin
            fill_cnt_reg <= '0;
        end
        else if (cmd.scroll_write)
        begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
        if (cmd.load_result)
        begin
            res_entry_reg    <= (is_read && range_ok_reg) ? rd_data : '0;
            res_row_reg      <= RROW_W'(cur_row_reg);
            res_col_reg      <= RCOL_W'(cur_col_reg);
            res_scrolled_reg <= scrolled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            fill_addr_reg <= '0;
            scrolled_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.put_write && !sts.col_last)
            begin
                cur_col_reg <= cur_col_reg + 1'b1;
            end
            if (cmd.next_row)
            begin
                cur_col_reg <= '0;
                if (!sts.row_last)
                begin
                    cur_row_reg <= cur_row_reg + 1'b1;
                end
            end
            // old top row becomes the blank bottom row
            if (cmd.scroll_setup)
            begin
                fill_addr_reg <= ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
                top_reg       <= top_next;
                scrolled_reg  <= 1'b1;
            end
            else if (cmd.scroll_write || cmd.clear_write)
            begin
                fill_addr_reg <= fill_addr_reg + 1'b1;
            end
        end
    end

    tmtw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.read),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign read_entry    = res_entry_reg;
    assign cursor_row    = res_row_reg;
    assign cursor_column = res_col_reg;
    assign scrolled      = res_scrolled_reg;

endmodule

[hw/rtl/text_mode_terminal_writer_top.sv]
// Text terminal over a ROWS x COLUMNS store of 16-bit cells (character in the low byte, colour
// in the high byte), one item at a time through a controller and a datapath around a single
// cell memory with one write and one registered read port. A put on the last column goes on
// through the new-row step, and a new row past the last one scrolls: rows rotate through a
// top-row pointer and only the new bottom row is rewritten, one cell per cycle through the
// memory's write port. After reset the store is filled with spaces in colour 0x07, one cell
// per cycle; no item is accepted during the fill, but text_colour can be written meanwhile.
// The next item is taken while a result still waits at the output.
module text_mode_terminal_writer_top
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    tmtw_in_if.sink            request,
    tmtw_out_if.source         response,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COLOUR_W-1:0] text_colour_reg;
    logic                cfg_write;
    ctrl_cmd_t           cmd;
    ctrl_sts_t           sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOUR);
    assign prdata    = (paddr[2] == REG_TEXT_COLOUR) ? PDATA_W'(text_colour_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_colour_reg <= RESET_COLOUR;
        end
        else if (cfg_write)
        begin
            text_colour_reg <= pwdata[COLOUR_W-1:0];
        end
    end

    tmtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tmtw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .text_colour   (text_colour_reg),
        .func          (request.func),
        .char_code     (request.char_code),
        .read_row      (request.read_row),
        .read_column   (request.read_column),
        .read_entry    (response.read_entry),
        .cursor_row    (response.cursor_row),
        .cursor_column (response.cursor_column),
        .scrolled      (response.scrolled)
    );

endmodule

[hw/rtl/tmtw_checker.sv]
`include "text_mode_terminal_writer_top_defines.svh"

module tmtw_port_checker
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ENTRY_W-1:0] read_entry,
    input logic [RROW_W-1:0]  cursor_row,
    input logic [RCOL_W-1:0]  cursor_column,
    input logic               scrolled
);

    `TMTW_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> (!out_valid && !in_ready))
    `TMTW_ASSERT(a_one_item_at_a_time, (in_valid && in_ready) |=> !in_ready)
    `TMTW_ASSERT(a_result_held, (out_valid && !out_ready) |=> (out_valid
        && $stable(read_entry) && $stable(cursor_row)
        && $stable(cursor_column) && $stable(scrolled)))
    `TMTW_ASSERT(a_scroll_lands_bottom, (out_valid && scrolled) |-> (cursor_row ==
        RROW_W'(ROWS - 1) && cursor_column == '0 && read_entry == '0))
    `TMTW_ASSERT(a_cursor_on_screen, out_valid |-> (int'(cursor_row) < ROWS
        && int'(cursor_column) < COLUMNS))

endmodule

bind text_mode_terminal_writer_top tmtw_port_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmtw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (request.valid),
    .in_ready      (request.ready),
    .out_valid     (response.valid),
    .out_ready     (response.ready),
    .read_entry    (response.read_entry),
    .cursor_row    (response.cursor_row),
    .cursor_column (response.cursor_column),
    .scrolled      (response.scrolled)
);

[dv/tmtw_checker.sv]
module tmtw_checker
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    tmtw_in_if                 request,
    tmtw_out_if                response,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [RROW_W-1:0]  row;
        logic [RCOL_W-1:0]  column;
        logic               scrolled;
    } cursor_result_t;

    logic [ENTRY_W-1:0]  screen [ROWS*COLUMNS];
    logic [COLOUR_W-1:0] colour;
    int                  row_pos;
    int                  col_pos;
    cursor_result_t      expected_results [$];
    cursor_result_t      predicted;
    cursor_result_t      oldest;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic advance_row(output logic scrolled);
        scrolled = 1'b0;
        col_pos  = 0;
        row_pos++;
        if (row_pos >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = 0; i < COLUMNS; i++)
                screen[(ROWS - 1) * COLUMNS + i] = {colour, SPACE_CODE};
            row_pos  = ROWS - 1;
            scrolled = 1'b1;
        end
    endtask

    task automatic predict_cursor(input logic [FUNC_W-1:0] func,
                                  input logic [CHAR_W-1:0] ch,
                                  input logic [RROW_W-1:0] rr,
                                  input logic [RCOL_W-1:0] rc,
                                  output cursor_result_t   res);
        logic scrolled;
        scrolled  = 1'b0;
        res.entry = '0;
        if (func == FUNC_READ)
        begin
            if (rr < ROWS && rc < COLUMNS)
                res.entry = screen[rr * COLUMNS + rc];
        end
        else if (ch == NEWLINE_CODE)
        begin
            advance_row(scrolled);
        end
        else
        begin
            screen[row_pos * COLUMNS + col_pos] = {colour, ch};
            col_pos++;
            if (col_pos >= COLUMNS)
                advance_row(scrolled);
        end
        res.row      = RROW_W'(row_pos);
        res.column   = RCOL_W'(col_pos);
        res.scrolled = scrolled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS * COLUMNS; i++)
                screen[i] = {RESET_COLOUR, SPACE_CODE};
            colour  = RESET_COLOUR;
            row_pos = 0;
            col_pos = 0;
            expected_results.delete();
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item waiting, entry 0x%0h",
                                              response.read_entry));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (response.read_entry !== oldest.entry)
                        report_mismatch($sformatf("read_entry got 0x%0h expected 0x%0h",
                                                  response.read_entry, oldest.entry));
                    if (response.cursor_row !== oldest.row)
                        report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                                  response.cursor_row, oldest.row));
                    if (response.cursor_column !== oldest.column)
                        report_mismatch($sformatf("cursor_column got %0d expected %0d",
                                                  response.cursor_column, oldest.column));
                    if (response.scrolled !== oldest.scrolled)
                        report_mismatch($sformatf("scrolled got %0b expected %0b",
                                                  response.scrolled, oldest.scrolled));
                end
            end
            if (request.valid && request.ready)
            begin
                predict_cursor(request.func, request.char_code, request.read_row,
                               request.read_column, predicted);
                expected_results.push_back(predicted);
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOUR)
                colour = pwdata[COLOUR_W-1:0];
        end
        pending = expected_results.size();
    end

endmodule

[dv/tb.sv]
module tb;
    import tmtw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 5;

    localparam logic [PADDR_W-1:0] COLOUR_ADDR = 3'd0;
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = 3'd4;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int errors;
    int pending;
    int hold_requests = 0;
    int hold_seen     = 0;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;
    int puts_sent     = 0;
    int newlines_sent = 0;
    int reads_sent    = 0;
    int colours_set   = 0;

    tmtw_in_if  req_if ();
    tmtw_out_if rsp_if ();

    text_mode_terminal_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tmtw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic [CHAR_W-1:0] ch,
                             input logic [RROW_W-1:0] rr,
                             input logic [RCOL_W-1:0] rc);
        int gap;
        gap = send_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.func        = func;
        req_if.char_code   = ch;
        req_if.read_row    = rr;
        req_if.read_column = rc;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
        if (func == FUNC_READ)
            reads_sent++;
        else if (ch == NEWLINE_CODE)
            newlines_sent++;
        else
            puts_sent++;
    endtask

    task automatic send_random();
        int                pick;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            if ($urandom_range(0, 3) == 0)
                ch = CHAR_W'($urandom);
            else
                ch = CHAR_W'($urandom_range(32, 126));
            send_item(FUNC_PUT, ch, RROW_W'($urandom), RCOL_W'($urandom));
        end
        else if (pick < 70)
        begin
            send_item(FUNC_PUT, NEWLINE_CODE, RROW_W'($urandom), RCOL_W'($urandom));
        end
        else if (pick < 95)
        begin
            send_item(FUNC_READ, CHAR_W'($urandom), RROW_W'($urandom_range(0, ROWS - 1)),
                      RCOL_W'($urandom_range(0, COLUMNS - 1)));
        end
        else
        begin
            send_item(FUNC_READ, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
        end
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        req_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen    = hold_requests;
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!recv_calm && $urandom_range(0, 3) == 0)
            begin
                stall        = 1 + idle_len();
                rsp_if.ready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    initial
    begin
        logic [COLOUR_W-1:0] colour;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.func        = FUNC_PUT;
        req_if.char_code   = '0;
        req_if.read_row    = '0;
        req_if.read_column = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset contents, corners and reads off the screen
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'hFF, 5'd24, 7'd79);
        send_item(FUNC_READ, 8'h00, 5'd25, 7'd0);
        send_item(FUNC_READ, 8'h00, 5'd31, 7'd127);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd80);
        send_item(FUNC_READ, 8'h00, 5'd24, 7'd127);
        // puts at character extremes, read fields ignored
        send_item(FUNC_PUT, 8'h00, 5'd31, 7'd127);
        send_item(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
        send_item(FUNC_PUT, 8'h41, 5'd24, 7'd79);
        send_item(FUNC_PUT, SPACE_CODE, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'hFF, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd1);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd2);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd4);
        // newline moves the cursor only; a read with the newline code does not
        send_item(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_item(FUNC_PUT, 8'h7E, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'h00, 5'd1, 7'd0);
        send_item(FUNC_READ, NEWLINE_CODE, 5'd1, 7'd1);
        send_item(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);
        send_item(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       colour = 8'h00;
                1:       colour = 8'hFF;
                4:       colour = 8'h1E;
                default: colour = COLOUR_W'($urandom);
            endcase
            apb_write(COLOUR_ADDR, ($urandom & 32'hFFFF_FF00) | PDATA_W'(colour));
            if (p == 1)
                apb_write(SPARE_ADDR, $urandom);
            colours_set++;
            send_calm = (p == 3);
            recv_calm = (p == 3);
            if (p == 2)
                hold_requests++;
            repeat (PHASE_ITEMS) send_random();
        end
        drain();
        repeat (100) @(negedge clk);

        $display("sent %0d items: %0d puts, %0d newlines, %0d reads",
                 puts_sent + newlines_sent + reads_sent, puts_sent, newlines_sent, reads_sent);
        $display("%0d colour settings, one output hold-off of %0d cycles",
                 colours_set, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
